[rtl/feather_blend_accumulator_defines.svh]
// assertion macros for the feather blend accumulator
`ifndef FEATHER_BLEND_ACCUMULATOR_DEFINES_SVH
`define FEATHER_BLEND_ACCUMULATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, held off during reset
`define FBA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, held off during reset
`define FBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/fba_pkg.sv]
// shared types and constants for the feather blend accumulator
`default_nettype none

package fba_pkg;

	localparam logic [7:0] COLOR_MAX = 8'd255;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_ACC,
		B_DIV,
		B_OUT
	} back_state_t;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] weight;
		logic        last;
	} fba_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fba_q_status_t;

endpackage

`default_nettype wire

[rtl/fba_stream_if.sv]
// sample and result channel interfaces
`default_nettype none

interface fba_sample_if;
	logic        valid;
	logic        ready;
	logic        present;
	logic [7:0]  sample_red;
	logic [7:0]  sample_green;
	logic [7:0]  sample_blue;
	logic [19:0] source_column;
	logic [15:0] source_width;
	logic        last;

	modport source (
		output valid, present, sample_red, sample_green, sample_blue,
		output source_column, source_width, last,
		input  ready
	);
	modport sink (
		input  valid, present, sample_red, sample_green, sample_blue,
		input  source_column, source_width, last,
		output ready
	);
endinterface

interface fba_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] blend_red;
	logic [7:0] blend_green;
	logic [7:0] blend_blue;
	logic       covered;

	modport source (
		output valid, blend_red, blend_green, blend_blue, covered,
		input  ready
	);
	modport sink (
		input  valid, blend_red, blend_green, blend_blue, covered,
		output ready
	);
endinterface

`default_nettype wire

[rtl/feather_blend_accumulator.sv]
// Feather blend accumulator, top level. Each sample transaction carries one source
// image's candidate for the current output pixel; the front end computes its
// weight 0.5 - |col/width - 0.5| in Q0.16 with a divider that retires four
// quotient bits per cycle; it takes a sample, divides, then pushes the entry and
// may take the next sample in that same cycle. Weights pass through a short queue
// to the back end, which multiplies and accumulates one entry per cycle with
// saturating sums while accumulating and the queue is not empty. The sample marked
// last also closes the pixel: a divide for the three channels, then the output
// register, which waits while a previous result is untaken. The front end keeps
// taking samples for the next pixel meanwhile, up to the queue depth.
`default_nettype none
`include "feather_blend_accumulator_defines.svh"

module feather_blend_accumulator #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	fba_sample_if.sink   sample,
	fba_result_if.source result
);
	import fba_pkg::*;

	logic          push;
	logic          pop;
	fba_entry_t    push_entry;
	fba_entry_t    pop_entry;
	fba_q_status_t q_stat;

	fba_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	fba_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.q_stat     (q_stat)
	);

	fba_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.pop_entry (pop_entry),
		.pop       (pop),
		.result    (result)
	);

	`FBA_ASSERT_NOW(a_no_push_full, push, !q_stat.full, "push into full queue")
	`FBA_ASSERT_NOW(a_no_pop_empty, pop, !q_stat.empty, "pop from empty queue")
	`FBA_ASSERT_NOW(a_uncovered_black, result.valid && !result.covered,
		(result.blend_red == 8'd0) && (result.blend_green == 8'd0) &&
		(result.blend_blue == 8'd0), "uncovered result with nonzero color")
	`FBA_ASSERT_NEXT(a_push_frees_front, push && !sample.valid, sample.ready,
		"front not ready after handing off an entry")

endmodule

`default_nettype wire

[rtl/fba_front.sv]
// front end: takes samples and computes the feather weight with a radix-16 divider
`default_nettype none

module fba_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	fba_sample_if.sink                sample,
	input  wire fba_pkg::fba_q_status_t q_stat,
	output logic                      push,
	output fba_pkg::fba_entry_t       push_entry
);
	import fba_pkg::*;

	front_state_t state_q, state_d;
	logic [1:0]   step_q;
	logic [16:0]  rem_q, rem_d;
	logic [15:0]  quo_q, quo_d;
	logic [15:0]  low_q;
	logic [15:0]  width_q;
	logic         zero_q;
	logic [7:0]   red_q, green_q, blue_q;
	logic         last_q;
	logic         take;
	logic [15:0]  weight;

	// outputs
	always_comb begin
		sample.ready = 1'b0;
		push         = 1'b0;
		case (state_q)
			F_IDLE: begin
				sample.ready = 1'b1;
			end
			F_PUSH: begin
				sample.ready = !q_stat.full;
				push         = !q_stat.full;
			end
			default: begin
				sample.ready = 1'b0;
				push         = 1'b0;
			end
		endcase
	end

	assign take = sample.valid && sample.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (take) state_d = F_DIV;
			end
			F_DIV: begin
				if (step_q == 2'd3) state_d = F_PUSH;
			end
			F_PUSH: begin
				if (!q_stat.full) state_d = take ? F_DIV : F_IDLE;
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	// four restoring steps per cycle
	always_comb begin
		logic [16:0] r;
		logic [15:0] qv;
		r  = rem_q;
		qv = quo_q;
		for (int i = 0; i < 4; i++) begin
			r = {r[15:0], low_q[15-i]};
			if (r >= {1'b0, width_q}) begin
				r  = r - {1'b0, width_q};
				qv = {qv[14:0], 1'b1};
			end else begin
				qv = {qv[14:0], 1'b0};
			end
		end
		rem_d = r;
		quo_d = qv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			step_q  <= 2'd0;
		end else begin
			state_q <= state_d;
			if (take) begin
				step_q <= 2'd0;
			end else if (state_q == F_DIV) begin
				step_q <= step_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			// dividend is column * 4096; its top 16 bits are below width when not clamped
			rem_q   <= {1'b0, sample.source_column[19:4]};
			low_q   <= {sample.source_column[3:0], 12'd0};
			width_q <= sample.source_width;
			zero_q  <= !sample.present ||
			           (sample.source_column >= {sample.source_width, 4'd0});
			red_q   <= sample.sample_red;
			green_q <= sample.sample_green;
			blue_q  <= sample.sample_blue;
			last_q  <= sample.last;
		end else if (state_q == F_DIV) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
			low_q <= {low_q[11:0], 4'd0};
		end
	end

	// ratio at or past one half folds back: w = 1 - q
	assign weight = zero_q ? 16'd0 : (quo_q[15] ? 16'(~quo_q + 16'd1) : quo_q);

	assign push_entry.red    = red_q;
	assign push_entry.green  = green_q;
	assign push_entry.blue   = blue_q;
	assign push_entry.weight = weight;
	assign push_entry.last   = last_q;

endmodule

`default_nettype wire

[rtl/fba_queue.sv]
// small fifo between the front and back ends
`default_nettype none

module fba_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire fba_pkg::fba_entry_t push_entry,
	input  wire logic                pop,
	output fba_pkg::fba_entry_t      pop_entry,
	output fba_pkg::fba_q_status_t   q_stat
);
	import fba_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	fba_entry_t    mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign q_stat.full  = (count_q == CW'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign pop_entry    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

endmodule

`default_nettype wire

[rtl/fba_back.sv]
// back end: weighted accumulation and final per-channel division
`default_nettype none

module fba_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire fba_pkg::fba_q_status_t q_stat,
	input  wire fba_pkg::fba_entry_t    pop_entry,
	output logic                        pop,
	fba_result_if.source                result
);
	import fba_pkg::*;

	back_state_t state_q, state_d;
	logic        step_q;
	logic [26:0] acc_q [3];
	logic [26:0] acc_next [3];
	logic [19:0] weight_sum_q, weight_next;
	logic [26:0] dsum_q [3];
	logic [19:0] dw_q;
	logic [20:0] rem_q [3];
	logic [20:0] rem_d [3];
	logic [7:0]  quo_q [3];
	logic [7:0]  quo_d [3];
	logic [7:0]  color [3];
	logic [7:0]  avg [3];
	logic        load_out;
	logic        out_valid_q;
	logic [7:0]  out_red_q, out_green_q, out_blue_q;
	logic        out_covered_q;

	assign color[0] = pop_entry.red;
	assign color[1] = pop_entry.green;
	assign color[2] = pop_entry.blue;

	// outputs
	always_comb begin
		pop      = 1'b0;
		load_out = 1'b0;
		case (state_q)
			B_ACC: begin
				pop = !q_stat.empty;
			end
			B_OUT: begin
				load_out = !out_valid_q || result.ready;
			end
			default: begin
				pop      = 1'b0;
				load_out = 1'b0;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_ACC: begin
				if (pop && pop_entry.last) state_d = B_DIV;
			end
			B_DIV: begin
				if (step_q) state_d = B_OUT;
			end
			B_OUT: begin
				if (load_out) state_d = B_ACC;
			end
			default: begin
				state_d = B_ACC;
			end
		endcase
	end

	// saturating multiply-accumulate
	always_comb begin
		logic [23:0] prod;
		logic [27:0] s;
		logic [20:0] ws;
		for (int c = 0; c < 3; c++) begin
			prod = 24'(color[c]) * 24'(pop_entry.weight);
			s    = {1'b0, acc_q[c]} + 28'(prod);
			acc_next[c] = s[27] ? '1 : s[26:0];
		end
		ws          = {1'b0, weight_sum_q} + 21'(pop_entry.weight);
		weight_next = ws[20] ? '1 : ws[19:0];
	end

	// four quotient bits per channel per cycle
	always_comb begin
		logic [20:0] r;
		logic [7:0]  qv;
		logic [3:0]  bits;
		for (int c = 0; c < 3; c++) begin
			r    = rem_q[c];
			qv   = quo_q[c];
			bits = step_q ? dsum_q[c][3:0] : dsum_q[c][7:4];
			for (int i = 0; i < 4; i++) begin
				r = {r[19:0], bits[3-i]};
				if (r >= {1'b0, dw_q}) begin
					r  = r - {1'b0, dw_q};
					qv = {qv[6:0], 1'b1};
				end else begin
					qv = {qv[6:0], 1'b0};
				end
			end
			rem_d[c] = r;
			quo_d[c] = qv;
		end
	end

	// quotient above 255 caps; no weight means no color
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (dw_q == '0) begin
				avg[c] = 8'd0;
			end else if ({1'b0, dsum_q[c]} >= {dw_q, 8'd0}) begin
				avg[c] = COLOR_MAX;
			end else begin
				avg[c] = quo_q[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_ACC;
			step_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			weight_sum_q <= '0;
			for (int c = 0; c < 3; c++) acc_q[c] <= '0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				if (pop_entry.last) begin
					weight_sum_q <= '0;
					for (int c = 0; c < 3; c++) acc_q[c] <= '0;
				end else begin
					weight_sum_q <= weight_next;
					for (int c = 0; c < 3; c++) acc_q[c] <= acc_next[c];
				end
			end
			if (pop && pop_entry.last) begin
				step_q <= 1'b0;
			end else if (state_q == B_DIV) begin
				step_q <= !step_q;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_entry.last) begin
			dw_q <= weight_next;
			for (int c = 0; c < 3; c++) begin
				dsum_q[c] <= acc_next[c];
				rem_q[c]  <= 21'(acc_next[c][26:8]);
			end
		end else if (state_q == B_DIV) begin
			for (int c = 0; c < 3; c++) begin
				rem_q[c] <= rem_d[c];
				quo_q[c] <= quo_d[c];
			end
		end
		if (load_out) begin
			out_red_q     <= avg[0];
			out_green_q   <= avg[1];
			out_blue_q    <= avg[2];
			out_covered_q <= (dw_q != '0);
		end
	end

	assign result.valid       = out_valid_q;
	assign result.blend_red   = out_red_q;
	assign result.blend_green = out_green_q;
	assign result.blend_blue  = out_blue_q;
	assign result.covered     = out_covered_q;

endmodule

`default_nettype wire

[sim/feather_blend_accumulator_tb.sv]
// self-checking testbench for the feather blend accumulator
`timescale 1ns / 1ps

module feather_blend_accumulator_tb;
	import fba_pkg::*;

	localparam int IDLE_PCT = 29;
	localparam int RANDOM_ITEMS = 1230;
	localparam int SETTLE_CYCLES = 40;
	localparam int PRINT_LIMIT = 50;

	typedef struct {
		bit        present;
		bit [7:0]  red;
		bit [7:0]  green;
		bit [7:0]  blue;
		bit [19:0] column;
		bit [15:0] width;
		bit        last;
	} sample_t;

	typedef struct {
		bit [7:0] red;
		bit [7:0] green;
		bit [7:0] blue;
		bit       covered;
	} blend_t;

	logic clk;
	logic arst_n;

	fba_sample_if sample_ch ();
	fba_result_if result_ch ();

	feather_blend_accumulator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch.sink),
		.result (result_ch.source)
	);

	// running sums of the pixel being built
	longint unsigned red_acc;
	longint unsigned green_acc;
	longint unsigned blue_acc;
	longint unsigned weight_acc;

	blend_t expected_blends[$];
	int     mismatches;
	bit     steady;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	function automatic longint unsigned feather_weight(bit [19:0] column, bit [15:0] width);
		bit [31:0] ratio;
		if (width == 0)
			return 0;
		ratio = {column, 12'b0} / width;
		if (ratio >= 32'h10000)
			return 0;
		if (ratio >= 32'h8000)
			return 32'h10000 - ratio;
		return ratio;
	endfunction

	function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b,
			longint unsigned cap);
		return (a + b > cap) ? cap : a + b;
	endfunction

	function automatic bit [7:0] channel_mean(longint unsigned sum, longint unsigned wsum);
		longint unsigned q;
		q = sum / wsum;
		return (q > COLOR_MAX) ? COLOR_MAX : q[7:0];
	endfunction

	// fold one accepted sample into the sums, close the pixel on last
	task automatic accumulate_sample(input sample_t s);
		longint unsigned w;
		blend_t b;
		if (s.present) begin
			w = feather_weight(s.column, s.width);
			red_acc = sat_sum(red_acc, s.red * w, (64'd1 << 27) - 1);
			green_acc = sat_sum(green_acc, s.green * w, (64'd1 << 27) - 1);
			blue_acc = sat_sum(blue_acc, s.blue * w, (64'd1 << 27) - 1);
			weight_acc = sat_sum(weight_acc, w, (64'd1 << 20) - 1);
		end
		if (s.last) begin
			if (weight_acc != 0) begin
				b.red = channel_mean(red_acc, weight_acc);
				b.green = channel_mean(green_acc, weight_acc);
				b.blue = channel_mean(blue_acc, weight_acc);
				b.covered = 1'b1;
			end else begin
				b = '{8'd0, 8'd0, 8'd0, 1'b0};
			end
			expected_blends.push_back(b);
			red_acc = 0;
			green_acc = 0;
			blue_acc = 0;
			weight_acc = 0;
		end
	endtask

	task automatic send_sample(input sample_t s);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.present <= s.present;
		sample_ch.sample_red <= s.red;
		sample_ch.sample_green <= s.green;
		sample_ch.sample_blue <= s.blue;
		sample_ch.source_column <= s.column;
		sample_ch.source_width <= s.width;
		sample_ch.last <= s.last;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		accumulate_sample(s);
	endtask

	// hold the sender off until every pending pixel has come back
	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_blends.size() != 0)
			@(posedge clk);
	endtask

	function automatic sample_t make_sample(bit present, bit [7:0] r, bit [7:0] g,
			bit [7:0] b, bit [19:0] column, bit [15:0] width, bit last);
		sample_t s;
		s = '{present, r, g, b, column, width, last};
		return s;
	endfunction

	function automatic sample_t random_sample(bit last, bit heavy);
		sample_t s;
		s.present = heavy || ($urandom_range(99) < 85);
		s.red = heavy ? 8'($urandom_range(255, 200)) : 8'($urandom);
		s.green = heavy ? 8'($urandom_range(255, 200)) : 8'($urandom);
		s.blue = heavy ? 8'($urandom_range(255, 200)) : 8'($urandom);
		case ($urandom_range(9))
			0: s.width = 16'd0;
			1: s.width = 16'($urandom_range(15, 1));
			2: s.width = 16'hFFFF;
			default: s.width = 16'($urandom_range(65535, 1));
		endcase
		if (heavy)
			s.column = 20'(32'(s.width) * 8 + $urandom_range(15));
		else begin
			case ($urandom_range(9))
				0: s.column = 20'($urandom);
				1: s.column = 20'(32'(s.width) * 16 - $urandom_range(3));
				default: s.column = 20'($urandom_range(32'(s.width) * 16));
			endcase
		end
		s.last = last;
		return s;
	endfunction

	task automatic test_weight_extremes();
		send_sample(make_sample(1, 200, 100, 50, 0, 100, 1));
		send_sample(make_sample(1, 200, 100, 50, 800, 100, 1));
		send_sample(make_sample(1, 10, 20, 30, 1600, 100, 1));
		send_sample(make_sample(1, 255, 255, 255, 20'hFFFFF, 1, 1));
		send_sample(make_sample(1, 255, 255, 255, 1234, 0, 1));
		// weight of one lsb just inside the right edge
		send_sample(make_sample(1, 255, 128, 1, 1048559, 16'hFFFF, 1));
		send_sample(make_sample(1, 7, 8, 9, 20'hFFFFF, 16'hFFFF, 1));
		send_sample(make_sample(1, 99, 99, 99, 524280, 16'hFFFF, 1));
		drain_results();
	endtask

	task automatic test_not_covered();
		send_sample(make_sample(0, 255, 255, 255, 800, 100, 0));
		send_sample(make_sample(0, 255, 255, 255, 800, 100, 0));
		send_sample(make_sample(0, 255, 255, 255, 800, 100, 1));
		send_sample(make_sample(1, 255, 255, 255, 0, 50, 0));
		send_sample(make_sample(0, 255, 255, 255, 400, 50, 1));
		drain_results();
	endtask

	task automatic test_mixed_pixel();
		send_sample(make_sample(1, 255, 0, 0, 800, 100, 0));
		send_sample(make_sample(0, 0, 255, 0, 800, 100, 0));
		send_sample(make_sample(1, 0, 0, 255, 400, 100, 0));
		send_sample(make_sample(1, 0, 0, 0, 0, 100, 1));
		send_sample(make_sample(1, 0, 0, 0, 800, 100, 0));
		send_sample(make_sample(1, 255, 255, 255, 1200, 100, 1));
		send_sample(make_sample(1, 1, 254, 127, 3, 7, 0));
		send_sample(make_sample(1, 254, 1, 128, 111, 7, 1));
		drain_results();
	endtask

	task automatic test_random_pixels();
		int sent;
		int run_len;
		int pick;
		bit heavy;
		sample_t s;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			heavy = 1'b0;
			pick = $urandom_range(99);
			if (pick < 3) begin
				// long runs of strong samples push the sums into saturation
				run_len = $urandom_range(40, 17);
				heavy = 1'b1;
			end else if (pick < 13) begin
				run_len = 1;
			end else begin
				run_len = $urandom_range(16, 2);
			end
			steady = (sent >= 400 && sent < 600);
			for (int i = 0; i < run_len; i++) begin
				s = random_sample(i == run_len - 1, heavy);
				send_sample(s);
				sent++;
			end
		end
		steady = 1'b0;
		drain_results();
	endtask

	initial begin : result_checker
		blend_t want;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				if (expected_blends.size() == 0) begin
					report_mismatch("result with no pixel pending", result_ch.covered, 0);
				end else begin
					want = expected_blends.pop_front();
					if (result_ch.blend_red !== want.red)
						report_mismatch("blend_red", result_ch.blend_red, want.red);
					if (result_ch.blend_green !== want.green)
						report_mismatch("blend_green", result_ch.blend_green, want.green);
					if (result_ch.blend_blue !== want.blue)
						report_mismatch("blend_blue", result_ch.blend_blue, want.blue);
					if (result_ch.covered !== want.covered)
						report_mismatch("covered", result_ch.covered, want.covered);
				end
			end
			result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin
		mismatches = 0;
		steady = 1'b0;
		red_acc = 0;
		green_acc = 0;
		blue_acc = 0;
		weight_acc = 0;
		arst_n <= 1'b0;
		sample_ch.valid <= 1'b0;
		sample_ch.present <= 1'b0;
		sample_ch.sample_red <= '0;
		sample_ch.sample_green <= '0;
		sample_ch.sample_blue <= '0;
		sample_ch.source_column <= '0;
		sample_ch.source_width <= '0;
		sample_ch.last <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_weight_extremes();
		test_not_covered();
		test_mixed_pixel();
		test_random_pixels();

		// anything arriving now has no pixel behind it
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
